FILE: rtl/nlt_pkg.sv
// Shared types and constants for the node liveness tracker.
// No dependencies; used by nlt_ctrl, nlt_dpath and node_liveness_tracker.
package nlt_pkg;

  localparam int AGE_W       = 8;
  localparam int ID_W        = 4;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  localparam logic [AGE_W-1:0] AGE_RESET     = 8'd21;
  localparam logic [AGE_W-1:0] OFFLINE_RESET = 8'd10;
  localparam logic [AGE_W-1:0] CLOSED_RESET  = 8'd20;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OFFLINE = 1'b0;
  localparam cfg_idx_t CFG_CLOSED  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_OFFLINE = 2'd1,
    ST_CLOSED  = 2'd2
  } node_st_t;

  typedef struct packed {
    node_st_t         st;
    logic [AGE_W-1:0] age;
  } node_rec_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } fsm_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic s2_busy;
    logic pend_vld;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/nlt_ctrl.sv
// Sequencer for the node liveness tracker: accept, scan, flush of the final result.
// Depends on nlt_pkg.
module nlt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nlt_pkg::sts_t sts,
  output nlt_pkg::cmd_t cmd
);

  nlt_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      nlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = nlt_pkg::S_SCAN;
        end
      end
      nlt_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_done && !sts.s2_busy) begin
          state_nxt = nlt_pkg::S_FLUSH;
        end
      end
      nlt_pkg::S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.pend_vld || sts.out_free) begin
          state_nxt = nlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = nlt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/nlt_dpath.sv
// Datapath: node table memory, age update pipeline, pending result and output register.
// Depends on nlt_pkg.
module nlt_dpath #(
  parameter int NODES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nlt_pkg::cmd_t                cmd,
  output nlt_pkg::sts_t                sts,
  input  logic [nlt_pkg::ID_W-1:0]     in_id,
  input  logic                         cfg_we,
  input  nlt_pkg::cfg_idx_t            cfg_idx,
  input  logic [nlt_pkg::AGE_W-1:0]    cfg_val,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [nlt_pkg::ID_W-1:0]     out_idx,
  output logic                         out_st,
  output logic                         out_last
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int MW = (IW > nlt_pkg::ID_W) ? IW : nlt_pkg::ID_W;

  nlt_pkg::node_rec_t mem [NODES];
  nlt_pkg::node_rec_t rd_data_r;
  logic [NODES-1:0]   vld_r;

  logic [nlt_pkg::AGE_W-1:0] off_thr_r, cls_thr_r;
  logic [nlt_pkg::ID_W-1:0]  id_r;
  logic                      id_ok_r;
  logic [CW-1:0]             idx_r;
  logic [nlt_pkg::CNT_W-1:0] cnt_r;
  logic                      s2_vld_r;
  logic [IW-1:0]             s2_idx_r;
  logic                      pend_vld_r;
  logic [nlt_pkg::ID_W-1:0]  pend_idx_r;
  logic                      pend_st_r;
  logic                      out_vld_r, out_st_r, out_last_r;
  logic [nlt_pkg::ID_W-1:0]  out_idx_r;

  logic                      issue_done, out_free, rd_en, can_load;
  logic                      hit, closed, rec, stall, adv2, push_mid, push_fin;
  logic [MW-1:0]             s2_idx_ext;
  logic [nlt_pkg::AGE_W-1:0] cur_age, new_age;
  logic [nlt_pkg::AGE_W:0]   inc;
  nlt_pkg::node_st_t         cur_st, new_st;

  assign issue_done = (idx_r == CW'(NODES));
  assign out_free   = !out_vld_r || out_rdy;
  assign s2_idx_ext = MW'(s2_idx_r);

  always_comb begin
    hit = s2_vld_r && id_ok_r && (s2_idx_ext == MW'(id_r));
    if (hit) begin
      cur_age = '0;
      cur_st  = nlt_pkg::ST_RUNNING;
    end else if (vld_r[s2_idx_r]) begin
      cur_age = rd_data_r.age;
      cur_st  = rd_data_r.st;
    end else begin
      cur_age = nlt_pkg::AGE_RESET;
      cur_st  = nlt_pkg::ST_CLOSED;
    end
    inc    = {1'b0, cur_age} + 9'd1;
    closed = inc > {1'b0, cls_thr_r};
    if (closed) begin
      new_age = cur_age;
      new_st  = nlt_pkg::ST_CLOSED;
    end else begin
      new_age = inc[nlt_pkg::AGE_W-1:0];
      new_st  = (inc > {1'b0, off_thr_r}) ? nlt_pkg::ST_OFFLINE : cur_st;
    end
    rec      = !closed && (cnt_r < nlt_pkg::CNT_W'(nlt_pkg::MAX_RESULTS));
    stall    = rec && pend_vld_r && !out_free;
    adv2     = s2_vld_r && !stall;
    can_load = !s2_vld_r || adv2;
    rd_en    = cmd.issue && !issue_done && can_load;
    push_mid = adv2 && rec && pend_vld_r;
    push_fin = cmd.flush && pend_vld_r && out_free;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
      s2_idx_r  <= idx_r[IW-1:0];
    end
    if (adv2) begin
      mem[s2_idx_r] <= '{st: new_st, age: new_age};
    end
    if (cmd.start) begin
      id_r    <= in_id;
      id_ok_r <= (32'(in_id) < NODES);
    end
    if (adv2 && rec) begin
      pend_idx_r <= s2_idx_ext[nlt_pkg::ID_W-1:0];
      pend_st_r  <= (new_st != nlt_pkg::ST_RUNNING);
    end
    if (push_mid || push_fin) begin
      out_idx_r  <= pend_idx_r;
      out_st_r   <= pend_st_r;
      out_last_r <= push_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      off_thr_r  <= nlt_pkg::OFFLINE_RESET;
      cls_thr_r  <= nlt_pkg::CLOSED_RESET;
      idx_r      <= '0;
      cnt_r      <= '0;
      s2_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          nlt_pkg::CFG_OFFLINE: off_thr_r <= cfg_val;
          nlt_pkg::CFG_CLOSED:  cls_thr_r <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.start) begin
        idx_r <= '0;
        cnt_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + CW'(1);
      end
      if (adv2 && rec) begin
        cnt_r <= cnt_r + nlt_pkg::CNT_W'(1);
      end
      if (rd_en) begin
        s2_vld_r <= 1'b1;
      end else if (adv2) begin
        s2_vld_r <= 1'b0;
      end
      if (adv2) begin
        vld_r[s2_idx_r] <= 1'b1;
      end
      if (adv2 && rec) begin
        pend_vld_r <= 1'b1;
      end else if (push_fin) begin
        pend_vld_r <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.issue_done = issue_done;
  assign sts.s2_busy    = s2_vld_r;
  assign sts.pend_vld   = pend_vld_r;
  assign sts.out_free   = out_free;

  assign out_vld  = out_vld_r;
  assign out_idx  = out_idx_r;
  assign out_st   = out_st_r;
  assign out_last = out_last_r;

endmodule

FILE: rtl/node_liveness_tracker.sv
// Top level of the node liveness tracker: ports, controller and datapath.
// Depends on nlt_pkg, nlt_ctrl and nlt_dpath.
//
// Usage: each transfer on the in_ stream names a node just heard from
// (tdata[3:0]). That node's age is cleared, then every node is aged in index
// order; nodes not yet closed are streamed out on out_ in index order with
// their state, and tlast marks the final one of the update (at most 16
// results; none when every node is closed).
// The cfg_ channel writes offline_threshold (index 0) and closed_threshold
// (index 1) and is always ready; the user must write it while the block is idle.
// The block does not enforce that rule. An item is done before in_tready
// rises again: NODES table reads at one per cycle while the scan does not stall
// (one read and one write port), the drain of the write-back stage, the exit
// from the scan and the flush of the final result. Output stalls add to this.
// The first result passes the read register and the pending slot before the
// output register; each result is held until the next listed node or the scan end.
// A result waits in the output register while out_tready is low; the scan
// stalls once the next listed node finds the pending slot full as well.
// Reset: all nodes read as closed with age 21, thresholds return to 10 and
// 20, no result is pending; no clearing pass is needed.
module node_liveness_tracker #(
  parameter int NODES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [3:0] node_id
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [3:0] node_index, [4] node_state
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  nlt_pkg::cmd_t cmd;
  nlt_pkg::sts_t sts;
  logic [nlt_pkg::ID_W-1:0] res_idx;
  logic res_st;

  assign cfg_ready = 1'b1;

  nlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlt_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_id    (in_tdata[nlt_pkg::ID_W-1:0]),
    .cfg_we   (cfg_valid),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_idx  (res_idx),
    .out_st   (res_st),
    .out_last (out_tlast)
  );

  assign out_tdata = {3'b000, res_st, res_idx};

endmodule
